FILE: rtl/core/gprd_pkg.sv
// Shared types, codes and helpers of the gamepad report decoder.
package gprd_pkg;

    localparam int unsigned IN_TDATA_W  = 96;
    localparam int unsigned OUT_TDATA_W = 24;
    localparam int unsigned CFG_DATA_W  = 40;
    localparam int unsigned CFG_INDEX_W = 8;

    localparam logic [7:0]  EXPECTED_LENGTH_RESET = 8'd8;
    localparam logic [39:0] RELEASE_TIME_RESET    = 40'd100000000;

    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_LENGTH = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_TIME    = 8'd1;

    typedef enum logic [1:0] {
        KIND_UPDATE  = 2'd0,
        KIND_REJECT  = 2'd1,
        KIND_SUMMARY = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REPORT,
        ST_SCAN_DIFF,
        ST_SCAN_TEST,
        ST_SUMMARY
    } t_state;

    typedef struct packed {
        logic latch;
        logic emit_report;
        logic calc_diff;
        logic emit_release;
        logic next_pad;
        logic emit_summary;
    } t_dp_cmd;

    typedef struct packed {
        logic pad_expire;
        logic last_pad;
        logic out_free;
    } t_dp_stat;

    // Report byte 3 carries start/back in bits 4..5, byte 4 carries the
    // remaining buttons in bits 2..7.
    function automatic logic [7:0] remap_buttons(input logic [7:0] b3, input logic [7:0] b4);
        remap_buttons = {b4[7:2], b3[5:4]};
    endfunction

    function automatic logic [3:0] remap_direction(input logic [7:0] b3);
        remap_direction = b3[3:0];
    endfunction

endpackage

FILE: rtl/core/gprd_ctrl.sv
// Sequencing state machine of the gamepad report decoder.
module gprd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_op,
    output logic              o_in_ready,
    input  gprd_pkg::t_dp_stat i_stat,
    output gprd_pkg::t_dp_cmd  o_cmd
);
    import gprd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_in_op ? ST_SCAN_DIFF : ST_REPORT;
                end
            end
            ST_REPORT: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN_DIFF: begin
                n_state = ST_SCAN_TEST;
            end
            ST_SCAN_TEST: begin
                // An expiring pad waits here until its update can be stored.
                if (!i_stat.pad_expire || i_stat.out_free) begin
                    n_state = i_stat.last_pad ? ST_SUMMARY : ST_SCAN_DIFF;
                end
            end
            ST_SUMMARY: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready         = 1'b0;
        o_cmd              = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            ST_REPORT: begin
                o_cmd.emit_report = i_stat.out_free;
            end
            ST_SCAN_DIFF: begin
                o_cmd.calc_diff = 1'b1;
            end
            ST_SCAN_TEST: begin
                o_cmd.emit_release = i_stat.pad_expire && i_stat.out_free;
                o_cmd.next_pad     = !i_stat.pad_expire || i_stat.out_free;
            end
            ST_SUMMARY: begin
                o_cmd.emit_summary = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/core/gprd_dp.sv
// Datapath of the gamepad report decoder: registers, pad store, age test, result register.
module gprd_dp #(
    parameter int unsigned PAD_COUNT = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gprd_pkg::t_dp_cmd                   i_cmd,
    output gprd_pkg::t_dp_stat                  o_stat,
    input  logic                                i_op,
    input  logic [7:0]                          i_packet_length,
    input  logic [7:0]                          i_pad_select,
    input  logic [7:0]                          i_first_button_byte,
    input  logic [7:0]                          i_second_button_byte,
    input  logic [63:0]                         i_now_time,
    input  logic                                i_cfg_we,
    input  logic [gprd_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [gprd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output gprd_pkg::t_kind                     o_kind,
    output logic [1:0]                          o_pad_index,
    output logic [7:0]                          o_button_bits,
    output logic [3:0]                          o_direction_bits,
    output logic [3:0]                          o_released_mask,
    output logic                                o_last
);
    import gprd_pkg::*;

    localparam int unsigned PAD_W = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

    logic [7:0]           r_expected_length;
    logic [39:0]          r_release_time;

    logic [7:0]           r_len;
    logic [7:0]           r_sel;
    logic [7:0]           r_b3;
    logic [7:0]           r_b4;
    logic [63:0]          r_now;
    logic [PAD_W-1:0]     r_idx;
    logic [PAD_COUNT-1:0] r_mask;

    logic [7:0]           r_held_buttons [PAD_COUNT];
    logic [3:0]           r_held_dir     [PAD_COUNT];
    logic [63:0]          r_report_time  [PAD_COUNT];

    logic [64:0]          n_diff;
    logic [64:0]          r_diff;
    logic                 r_held;

    logic                 report_ok;
    logic                 pad_expire;
    logic [PAD_W+1:0]     idx_ext;
    logic [PAD_COUNT+3:0] mask_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_length <= EXPECTED_LENGTH_RESET;
            r_release_time    <= RELEASE_TIME_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_EXPECTED_LENGTH) begin
                r_expected_length <= i_cfg_data[7:0];
            end else if (i_cfg_index == REG_RELEASE_TIME) begin
                r_release_time <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_len <= i_packet_length;
            r_sel <= i_pad_select;
            r_b3  <= i_first_button_byte;
            r_b4  <= i_second_button_byte;
            r_now <= i_now_time;
        end
    end

    // One pointer serves both the report write and the tick scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_idx  <= i_op ? '0 : i_pad_select[PAD_W-1:0];
            r_mask <= '0;
        end else begin
            if (i_cmd.emit_release) begin
                r_mask <= r_mask | (PAD_COUNT'(1) << r_idx);
            end
            if (i_cmd.next_pad) begin
                r_idx <= r_idx + PAD_W'(1);
            end
        end
    end

    assign report_ok = (r_len == r_expected_length) && (r_sel < 8'(PAD_COUNT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < int'(PAD_COUNT); i++) begin
                r_held_buttons[i] <= '0;
                r_held_dir[i]     <= '0;
            end
        end else if (i_cmd.emit_report && report_ok) begin
            r_held_buttons[r_idx] <= remap_buttons(r_b3, r_b4);
            r_held_dir[r_idx]     <= remap_direction(r_b3);
        end else if (i_cmd.emit_release) begin
            r_held_buttons[r_idx] <= '0;
            r_held_dir[r_idx]     <= '0;
        end
    end

    // The report time only matters while the pad holds input, so it needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_report && report_ok) begin
            r_report_time[r_idx] <= r_now;
        end
    end

    // Bit 64 of the difference is the borrow: set when the tick is older than the report.
    assign n_diff = {1'b0, r_now} - {1'b0, r_report_time[r_idx]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_diff) begin
            r_diff <= n_diff;
            r_held <= (r_held_buttons[r_idx] != 8'd0) || (r_held_dir[r_idx] != 4'd0);
        end
    end

    assign pad_expire = r_held && !r_diff[64] && (r_diff[63:0] >= {24'd0, r_release_time});

    assign idx_ext  = {2'b00, r_idx};
    assign mask_ext = {4'b0000, r_mask};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit_report || i_cmd.emit_release || i_cmd.emit_summary) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_report) begin
            o_kind           <= report_ok ? KIND_UPDATE : KIND_REJECT;
            o_pad_index      <= report_ok ? idx_ext[1:0] : 2'd0;
            o_button_bits    <= report_ok ? remap_buttons(r_b3, r_b4) : 8'd0;
            o_direction_bits <= report_ok ? remap_direction(r_b3) : 4'd0;
            o_released_mask  <= 4'd0;
            o_last           <= 1'b1;
        end else if (i_cmd.emit_release) begin
            o_kind           <= KIND_UPDATE;
            o_pad_index      <= idx_ext[1:0];
            o_button_bits    <= 8'd0;
            o_direction_bits <= 4'd0;
            o_released_mask  <= 4'd0;
            o_last           <= 1'b0;
        end else if (i_cmd.emit_summary) begin
            o_kind           <= KIND_SUMMARY;
            o_pad_index      <= 2'd0;
            o_button_bits    <= 8'd0;
            o_direction_bits <= 4'd0;
            o_released_mask  <= mask_ext[3:0];
            o_last           <= 1'b1;
        end
    end

    assign o_stat.pad_expire = pad_expire;
    assign o_stat.last_pad   = (r_idx == PAD_W'(PAD_COUNT - 1));
    assign o_stat.out_free   = !o_out_valid || i_out_ready;

endmodule

FILE: rtl/core/gamepad_report_decoder_with_release.sv
// Top level of the gamepad report decoder with timed release of idle pads.
//
// A report transaction (tuser 0) is latched, then loads its single result
// once the output register is free, and the input is free again after the
// result is loaded. A tick transaction (tuser 1) scans the pads one at a
// time (a 64-bit age subtraction is registered, then compared with the
// release time), so it occupies the block for the whole scan, and longer
// while the output register is held by a stalled consumer.
// Results are released through one output register, so the next transaction
// is taken while the last result still waits on the master side.
module gamepad_report_decoder_with_release #(
    parameter int unsigned PAD_COUNT = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // packet_length[7:0], pad_select[15:8], first_button_byte[23:16],
    // second_button_byte[31:24], now_time[95:32]
    input  logic [gprd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // operation[0]
    input  logic [0:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // pad_index[1:0], button_bits[9:2], direction_bits[13:10],
    // released_mask[17:14], zero[23:18]
    output logic [gprd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // kind[1:0]
    output logic [1:0]                          m_axis_tuser,
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gprd_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [gprd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import gprd_pkg::*;

    t_dp_cmd    cmd;
    t_dp_stat   stat;
    t_kind      out_kind;
    logic [1:0] out_pad;
    logic [7:0] out_buttons;
    logic [3:0] out_dir;
    logic [3:0] out_mask;

    assign o_cfg_ready = 1'b1;

    gprd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (s_axis_tuser[0]),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gprd_dp #(
        .PAD_COUNT (PAD_COUNT)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_stat               (stat),
        .i_op                 (s_axis_tuser[0]),
        .i_packet_length      (s_axis_tdata[7:0]),
        .i_pad_select         (s_axis_tdata[15:8]),
        .i_first_button_byte  (s_axis_tdata[23:16]),
        .i_second_button_byte (s_axis_tdata[31:24]),
        .i_now_time           (s_axis_tdata[95:32]),
        .i_cfg_we             (i_cfg_valid && o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .o_out_valid          (m_axis_tvalid),
        .i_out_ready          (m_axis_tready),
        .o_kind               (out_kind),
        .o_pad_index          (out_pad),
        .o_button_bits        (out_buttons),
        .o_direction_bits     (out_dir),
        .o_released_mask      (out_mask),
        .o_last               (m_axis_tlast)
    );

    assign m_axis_tuser = out_kind;
    assign m_axis_tdata = {6'd0, out_mask, out_dir, out_buttons, out_pad};

`ifndef SYNTH
    // A summary always closes the results of a tick.
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_SUMMARY)) |-> m_axis_tlast)
        else $error("summary result without tlast");

    // A rejected report yields one result with all payload bits clear.
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_REJECT))
            |-> (m_axis_tlast && (m_axis_tdata == '0)))
        else $error("rejected report result carries payload");

    // Updates that are not final come from a release and carry no inputs.
    a_release_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast)
            |-> ((m_axis_tuser == KIND_UPDATE) && (m_axis_tdata[17:2] == 16'd0)))
        else $error("release update carries input bits");
`endif

endmodule
